[rtl/core/baro_pressure_temp_compensation_macros.svh]
// Assertion macros for the barometric compensation core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define BPTC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("bptc: same-cycle check failed");
// next-cycle implication, disabled during reset
`define BPTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("bptc: next-cycle check failed");
`else
`define BPTC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BPTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/bptc_pkg.sv]
// Shared widths, register indexes and types for the barometric compensation core.
// No dependencies.
`timescale 1ns / 1ps
package bptc_pkg;

	localparam int CNT_W   = 24;  // raw conversion counts
	localparam int COEF_W  = 16;  // calibration coefficients
	localparam int IDX_W   = 3;   // register index
	localparam int TEMP_W  = 19;  // temperature result
	localparam int PRESS_W = 41;  // pressure result, Q15
	localparam int DT_W    = 25;  // temperature difference
	localparam int MUL_W   = 42;  // dT times a coefficient
	localparam int SQ_W    = 49;  // dT squared, non-negative
	localparam int Q_W     = 19;  // first-order temperature offset from 20.00 C
	localparam int T2_W    = 18;  // second-order temperature term
	localparam int OFF_W   = 36;  // first-order offset / sensitivity
	localparam int SQV_W   = 35;  // squares of temperature offsets
	localparam int CORR_W  = 39;  // second-order offset / sensitivity terms
	localparam int FIN_W   = 41;  // corrected offset / sensitivity
	localparam int PL_W    = 44;  // low partial product
	localparam int PH_W    = 46;  // high partial product
	localparam int PROD_W  = 66;  // full pressure product
	localparam int SPLIT_W = 20;  // low slice of the sensitivity
	localparam int PACC_W  = 46;  // pressure accumulation

	localparam logic signed [Q_W-1:0] T_REF_CENTI = 19'sd2000;
	// offset between the 20.00 C and -15.00 C thresholds
	localparam logic signed [Q_W-1:0] T_VLOW_OFS  = 19'sd3500;

	typedef enum logic [IDX_W-1:0] {
		REG_SENS  = 3'd0,
		REG_OFF   = 3'd1,
		REG_TCS   = 3'd2,
		REG_TCO   = 3'd3,
		REG_TREF  = 3'd4,
		REG_TSENS = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [COEF_W-1:0] sens;
		logic [COEF_W-1:0] off;
		logic [COEF_W-1:0] tcs;
		logic [COEF_W-1:0] tco;
		logic [COEF_W-1:0] tref;
		logic [COEF_W-1:0] tsens;
	} coeff_t;

endpackage

[rtl/core/baro_pressure_temp_compensation.sv]
// Nine register stages from the accepting edge to result valid; throughput one item per cycle
// while the output is not stalled.
// The nine-stage multiply/add pipeline sets the latency; a full output register
// under stall freezes every stage at once.
// Reset clears all stage valid bits and sets every coefficient to zero.
// Depends on bptc_pkg, bptc_regs and the assertion macro header.
`timescale 1ns / 1ps
`include "baro_pressure_temp_compensation_macros.svh"
module baro_pressure_temp_compensation (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bptc_pkg::IDX_W-1:0]          cfg_index,
	input  logic [bptc_pkg::COEF_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bptc_pkg::CNT_W-1:0]          pressure_count,
	input  logic [bptc_pkg::CNT_W-1:0]          temperature_count,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [bptc_pkg::TEMP_W-1:0]  temp_centi,
	output logic signed [bptc_pkg::PRESS_W-1:0] press_q15
);
	import bptc_pkg::*;

	coeff_t coeff;

	bptc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coeff     (coeff)
	);

	// global advance: everything moves unless the output item is held
	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic [8:0] vld_vec;

	assign en       = !(vld_s9 && out_stall);
	assign in_stall = vld_s9 && out_stall;
	assign vld_vec  = {vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// ---------------- stage 1: temperature difference ----------------
	logic        [CNT_W-1:0] d1_s1;
	logic signed [DT_W-1:0]  dt_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1 <= pressure_count;
			dt_s1 <= $signed({1'b0, temperature_count}) - $signed({1'b0, coeff.tref, 8'd0});
		end
	end

	// ---------------- stage 2: coefficient products and dT squared ----------------
	logic        [CNT_W-1:0] d1_s2;
	logic signed [MUL_W-1:0] pt_s2, poff_s2, psens_s2;
	logic        [SQ_W-1:0]  psq_s2;
	logic signed [2*DT_W-1:0] sq_full;

	assign sq_full = (2*DT_W)'(dt_s1) * (2*DT_W)'(dt_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s2    <= d1_s1;
			pt_s2    <= MUL_W'(dt_s1) * MUL_W'($signed({1'b0, coeff.tsens}));
			poff_s2  <= MUL_W'(dt_s1) * MUL_W'($signed({1'b0, coeff.tco}));
			psens_s2 <= MUL_W'(dt_s1) * MUL_W'($signed({1'b0, coeff.tcs}));
			psq_s2   <= sq_full[SQ_W-1:0];
		end
	end

	// ---------------- stage 3: scaled first-order terms ----------------
	// division toward zero: arithmetic shift plus one when negative with lost bits
	logic                    q_corr, off_corr, sens_corr;
	logic signed [Q_W-1:0]   q_c, qb_c;
	logic signed [OFF_W-1:0] off_c, sens_c;

	assign q_corr    = pt_s2[MUL_W-1] && (|pt_s2[22:0]);
	assign off_corr  = poff_s2[MUL_W-1] && (|poff_s2[6:0]);
	assign sens_corr = psens_s2[MUL_W-1] && (|psens_s2[7:0]);

	assign q_c  = $signed(pt_s2[MUL_W-1:23]) + $signed({{(Q_W-1){1'b0}}, q_corr});
	assign qb_c = $signed(pt_s2[MUL_W-1:23]) + $signed({{(Q_W-1){1'b0}}, q_corr}) + T_VLOW_OFS;

	assign off_c = $signed({4'd0, coeff.off, 16'd0})
		+ $signed({poff_s2[MUL_W-1], poff_s2[MUL_W-1:7]})
		+ $signed({{(OFF_W-1){1'b0}}, off_corr});
	assign sens_c = $signed({5'd0, coeff.sens, 15'd0})
		+ $signed({{2{psens_s2[MUL_W-1]}}, psens_s2[MUL_W-1:8]})
		+ $signed({{(OFF_W-1){1'b0}}, sens_corr});

	logic        [CNT_W-1:0] d1_s3;
	logic signed [Q_W-1:0]   q_s3, qb_s3;
	logic signed [OFF_W-1:0] off_s3, sens_s3;
	logic        [T2_W-1:0]  t2_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s3   <= d1_s2;
			q_s3    <= q_c;
			qb_s3   <= qb_c;
			off_s3  <= off_c;
			sens_s3 <= sens_c;
			t2_s3   <= psq_s2[SQ_W-1:31];
		end
	end

	// ---------------- stage 4: squares and final temperature ----------------
	logic signed [2*Q_W-1:0] x_full, y_full;
	logic                    low_c, vlow_c;
	logic signed [Q_W-1:0]   t2_term, temp_c;

	assign x_full  = (2*Q_W)'(q_s3) * (2*Q_W)'(q_s3);
	assign y_full  = (2*Q_W)'(qb_s3) * (2*Q_W)'(qb_s3);
	assign low_c   = q_s3[Q_W-1];
	assign vlow_c  = qb_s3[Q_W-1];
	assign t2_term = low_c ? $signed({1'b0, t2_s3}) : '0;
	assign temp_c  = T_REF_CENTI + q_s3 - t2_term;

	logic        [CNT_W-1:0] d1_s4;
	logic        [SQV_W-1:0] x_s4, y_s4;
	logic                    low_s4, vlow_s4;
	logic signed [OFF_W-1:0] off_s4, sens_s4;
	logic signed [TEMP_W-1:0] temp_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s4   <= d1_s3;
			x_s4    <= x_full[SQV_W-1:0];
			y_s4    <= y_full[SQV_W-1:0];
			low_s4  <= low_c;
			vlow_s4 <= vlow_c;
			off_s4  <= off_s3;
			sens_s4 <= sens_s3;
			temp_s4 <= temp_c;
		end
	end

	// ---------------- stage 5: second-order correction terms ----------------
	logic [SQV_W+2:0] x5;      // 5x
	logic [SQV_W+2:0] y7;      // 7y
	logic [SQV_W+3:0] y11;     // 11y
	logic [CORR_W-1:0] off2_c, sens2_c;

	assign x5  = {1'b0, x_s4, 2'b00} + {3'd0, x_s4};
	assign y7  = {y_s4, 3'b000} - {3'd0, y_s4};
	assign y11 = {1'b0, y_s4, 3'b000} + {3'd0, y_s4, 1'b0} + {4'd0, y_s4};

	always_comb begin
		off2_c  = '0;
		sens2_c = '0;
		if (low_s4) begin
			off2_c  = {2'd0, x5[SQV_W+2:1]} + (vlow_s4 ? {1'b0, y7} : '0);
			sens2_c = {3'd0, x5[SQV_W+2:2]} + (vlow_s4 ? {1'b0, y11[SQV_W+3:1]} : '0);
		end
	end

	logic        [CNT_W-1:0]  d1_s5;
	logic        [CORR_W-1:0] off2_s5, sens2_s5;
	logic signed [OFF_W-1:0]  off_s5, sens_s5;
	logic signed [TEMP_W-1:0] temp_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s5    <= d1_s4;
			off2_s5  <= off2_c;
			sens2_s5 <= sens2_c;
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			temp_s5  <= temp_s4;
		end
	end

	// ---------------- stage 6: corrected offset and sensitivity ----------------
	logic        [CNT_W-1:0]  d1_s6;
	logic signed [FIN_W-1:0]  off_f_s6, sens_f_s6;
	logic signed [TEMP_W-1:0] temp_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s6     <= d1_s5;
			off_f_s6  <= $signed({{(FIN_W-OFF_W){off_s5[OFF_W-1]}}, off_s5})
				- $signed({2'd0, off2_s5});
			sens_f_s6 <= $signed({{(FIN_W-OFF_W){sens_s5[OFF_W-1]}}, sens_s5})
				- $signed({2'd0, sens2_s5});
			temp_s6   <= temp_s5;
		end
	end

	// ---------------- stage 7: split pressure product ----------------
	logic        [PL_W-1:0]   pl_s7;
	logic signed [PH_W-1:0]   ph_s7;
	logic signed [FIN_W-1:0]  off_f_s7;
	logic signed [TEMP_W-1:0] temp_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s7    <= PL_W'(d1_s6) * PL_W'(sens_f_s6[SPLIT_W-1:0]);
			ph_s7    <= PH_W'($signed({1'b0, d1_s6}))
				* PH_W'($signed(sens_f_s6[FIN_W-1:SPLIT_W]));
			off_f_s7 <= off_f_s6;
			temp_s7  <= temp_s6;
		end
	end

	// ---------------- stage 8: partial product merge ----------------
	logic signed [PROD_W-1:0] prod_s8;
	logic signed [FIN_W-1:0]  off_f_s8;
	logic signed [TEMP_W-1:0] temp_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s8  <= $signed({ph_s7, {SPLIT_W{1'b0}}}) + $signed({{(PROD_W-PL_W){1'b0}}, pl_s7});
			off_f_s8 <= off_f_s7;
			temp_s8  <= temp_s7;
		end
	end

	// ---------------- stage 9: scale, subtract offset, output register ----------------
	logic                     p_corr;
	logic signed [PACC_W-1:0] press_c;

	assign p_corr  = prod_s8[PROD_W-1] && (|prod_s8[20:0]);
	assign press_c = $signed({prod_s8[PROD_W-1], prod_s8[PROD_W-1:21]})
		+ $signed({{(PACC_W-1){1'b0}}, p_corr})
		- $signed({{(PACC_W-FIN_W){off_f_s8[FIN_W-1]}}, off_f_s8});

	logic signed [PRESS_W-1:0] press_s9;
	logic signed [TEMP_W-1:0]  temp_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			press_s9 <= press_c[PRESS_W-1:0];
			temp_s9  <= temp_s8;
		end
	end

	assign out_valid  = vld_s9;
	assign temp_centi = temp_s9;
	assign press_q15  = press_s9;

	// ---------------- checks ----------------
	`BPTC_ASSERT_NEXT(a_stall_freezes_pipe, clk, arst_n, !en, $stable(vld_vec))
	`BPTC_ASSERT_IMPL(a_vlow_implies_low, clk, arst_n, vld_s4 && vlow_s4, low_s4)
	`BPTC_ASSERT_NEXT(a_warm_no_correction, clk, arst_n, en && vld_s4 && !low_s4, off2_s5 == '0 && sens2_s5 == '0)

endmodule

[rtl/core/bptc_regs.sv]
// Calibration coefficient register file, written by index.
// Depends on bptc_pkg.
`timescale 1ns / 1ps
module bptc_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bptc_pkg::IDX_W-1:0]  cfg_index,
	input  logic [bptc_pkg::COEF_W-1:0] cfg_data,
	output bptc_pkg::coeff_t            coeff
);
	import bptc_pkg::*;

	coeff_t coeff_q;

	// one register per coefficient; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SENS:  coeff_q.sens  <= cfg_data;
				REG_OFF:   coeff_q.off   <= cfg_data;
				REG_TCS:   coeff_q.tcs   <= cfg_data;
				REG_TCO:   coeff_q.tco   <= cfg_data;
				REG_TREF:  coeff_q.tref  <= cfg_data;
				REG_TSENS: coeff_q.tsens <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coeff = coeff_q;

endmodule

[tb/sv/baro_pressure_temp_compensation_tb.sv]
// Testbench for baro_pressure_temp_compensation: drives raw count pairs and coefficient writes,
// and checks every compensated reading against an in-bench integer predictor.
// Depends on bptc_pkg and the compensation core.
`timescale 1ns / 1ps
module baro_pressure_temp_compensation_tb;
	import bptc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 20;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};
	// unused register slots, writes there must be dropped
	localparam logic [IDX_W-1:0] IDX_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] IDX_SPARE_B = 3'd7;
	// compensation constants, centi-degrees and scale factors
	localparam longint T_ROOM = 64'sd2000;
	localparam longint T_COLD = -64'sd1500;
	localparam longint DIV_TEMP = 64'sd8388608;
	localparam longint DIV_T2 = 64'sd2147483648;
	localparam longint DIV_PRESS = 64'sd2097152;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic signed [PRESS_W-1:0] press;
	} reading_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [CNT_W-1:0] pressure_count;
	logic [CNT_W-1:0] temperature_count;
	logic out_valid;
	logic out_stall;
	logic signed [TEMP_W-1:0] temp_centi;
	logic signed [PRESS_W-1:0] press_q15;

	coeff_t cal;
	reading_t expected_readings[$];
	int mismatches = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit gaps_on = 1'b1;
	bit stall_on = 1'b1;

	baro_pressure_temp_compensation dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pressure_count(pressure_count),
		.temperature_count(temperature_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.temp_centi(temp_centi),
		.press_q15(press_q15)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// first- and second-order compensation of one count pair
	function automatic reading_t compensate(input logic [CNT_W-1:0] p, input logic [CNT_W-1:0] t);
		reading_t r;
		longint d1, dt, t1, off, sens, t2, x, y, off2, sens2, press;
		d1 = longint'(p);
		dt = longint'(t) - longint'(cal.tref) * 256;
		t1 = T_ROOM + (dt * longint'(cal.tsens)) / DIV_TEMP;
		off = longint'(cal.off) * 65536 + (longint'(cal.tco) * dt) / 128;
		sens = longint'(cal.sens) * 32768 + (longint'(cal.tcs) * dt) / 256;
		if (t1 < T_ROOM) begin
			t2 = (dt * dt) / DIV_T2;
			x = (t1 - T_ROOM) * (t1 - T_ROOM);
			off2 = 5 * x / 2;
			sens2 = off2 / 2;
			// extra term in the very cold range
			if (t1 < T_COLD) begin
				y = (t1 - T_COLD) * (t1 - T_COLD);
				off2 = off2 + 7 * y;
				sens2 = sens2 + 11 * y / 2;
			end
			t1 = t1 - t2;
			off = off - off2;
			sens = sens - sens2;
		end
		press = (d1 * sens) / DIV_PRESS - off;
		r.temp = t1[TEMP_W-1:0];
		r.press = press[PRESS_W-1:0];
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				$display("%0t: unexpected reading temp_centi %0d press_q15 %0d",
					$time, temp_centi, press_q15);
				mismatches++;
			end else begin
				want = expected_readings.pop_front();
				if (temp_centi !== want.temp) begin
					$display("%0t: temp_centi expected %0d got %0d", $time, want.temp, temp_centi);
					mismatches++;
				end
				if (press_q15 !== want.press) begin
					$display("%0t: press_q15 expected %0d got %0d", $time, want.press, press_q15);
					mismatches++;
				end
			end
		end
	end

	// receiver stall: long hold on request, else random bursts
	initial begin : rx_stall_gen
		int burst;
		burst = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (burst > 0) begin
				out_stall <= 1'b1;
				burst--;
			end else if (stall_on && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 19) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// offer one item, record its reading, wait until it is taken
	task automatic send_sample(input logic [CNT_W-1:0] p, input logic [CNT_W-1:0] t);
		int n;
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 19);
			repeat (n) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		pressure_count <= p;
		temperature_count <= t;
		expected_readings.push_back(compensate(p, t));
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_SENS: cal.sens = val;
			REG_OFF: cal.off = val;
			REG_TCS: cal.tcs = val;
			REG_TCO: cal.tco = val;
			REG_TREF: cal.tref = val;
			REG_TSENS: cal.tsens = val;
			default: ;
		endcase
	endtask

	// full calibration load, with stray writes to the unused slots
	task automatic load_calibration(input coeff_t c);
		write_reg(IDX_SPARE_A, COEF_W'($urandom));
		write_reg(REG_SENS, c.sens);
		write_reg(REG_OFF, c.off);
		write_reg(REG_TCS, c.tcs);
		write_reg(REG_TCO, c.tco);
		write_reg(REG_TREF, c.tref);
		write_reg(REG_TSENS, c.tsens);
		write_reg(IDX_SPARE_B, COEF_W'($urandom));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// stop offering and wait for every reading to come back
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_readings.size() != 0) @(posedge clk);
	endtask

	function automatic logic [COEF_W-1:0] pick_coeff();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return COEF_MAX;
			default: return COEF_W'($urandom);
		endcase
	endfunction

	function automatic coeff_t random_calibration();
		coeff_t c;
		c.sens = pick_coeff();
		c.off = pick_coeff();
		c.tcs = pick_coeff();
		c.tco = pick_coeff();
		c.tref = pick_coeff();
		c.tsens = pick_coeff();
		return c;
	endfunction

	function automatic logic [CNT_W-1:0] random_pressure();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return CNT_MAX;
			default: return CNT_W'($urandom);
		endcase
	endfunction

	// often near the reference temperature, some deep cold, some anywhere
	function automatic logic [CNT_W-1:0] random_temperature();
		longint center, v;
		center = longint'(cal.tref) * 256;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = center + longint'($urandom_range(0, 2097152)) - 1048576;
			4, 5: v = center - longint'($urandom_range(0, 4194304));
			6: v = ($urandom_range(0, 1) != 0) ? longint'(CNT_MAX) : 0;
			default: v = longint'($urandom_range(0, 32'(CNT_MAX)));
		endcase
		if (v < 0) v = 0;
		if (v > longint'(CNT_MAX)) v = longint'(CNT_MAX);
		return v[CNT_W-1:0];
	endfunction

	// reset values: all coefficients zero
	task automatic test_uncalibrated();
		send_sample('0, '0);
		send_sample(CNT_MAX, CNT_MAX);
		send_sample('0, CNT_MAX);
		send_sample(CNT_MAX, '0);
		drain_pipeline();
	endtask

	// every coefficient at full scale, count corners
	task automatic test_full_scale_coeffs();
		coeff_t c;
		c = '{sens: COEF_MAX, off: COEF_MAX, tcs: COEF_MAX, tco: COEF_MAX,
			tref: COEF_MAX, tsens: COEF_MAX};
		load_calibration(c);
		send_sample('0, '0);
		send_sample(CNT_MAX, CNT_MAX);
		send_sample('0, CNT_MAX);
		send_sample(CNT_MAX, '0);
		drain_pipeline();
	endtask

	// typical calibration around the 20.00 C and -15.00 C thresholds
	task automatic test_cold_thresholds();
		coeff_t c;
		longint center;
		longint offsets[9];
		c = '{sens: 16'd40127, off: 16'd36924, tcs: 16'd23317, tco: 16'd23282,
			tref: 16'd33464, tsens: 16'd28312};
		offsets = '{0, -296, -297, -300, -1036900, -1036996, -1037100, -4000000, 2000000};
		load_calibration(c);
		center = longint'(c.tref) * 256;
		foreach (offsets[i]) begin
			case (i % 3)
				0: send_sample(24'd9085466, CNT_W'(center + offsets[i]));
				1: send_sample('0, CNT_W'(center + offsets[i]));
				default: send_sample(CNT_MAX, CNT_W'(center + offsets[i]));
			endcase
		end
		drain_pipeline();
	endtask

	// random calibrations, each followed by a random batch
	task automatic test_random_calibrations();
		repeat (5) begin
			load_calibration(random_calibration());
			repeat (300) send_sample(random_pressure(), random_temperature());
			drain_pipeline();
		end
	endtask

	// long receiver hold while items keep coming, so the input stalls
	task automatic test_output_backpressure();
		gaps_on = 1'b0;
		hold_left = 250;
		repeat (60) send_sample(random_pressure(), random_temperature());
		drain_pipeline();
		gaps_on = 1'b1;
	endtask

	// closing stream at full rate on both sides
	task automatic test_full_rate_stream();
		gaps_on = 1'b0;
		stall_on = 1'b0;
		load_calibration(random_calibration());
		repeat (370) send_sample(random_pressure(), random_temperature());
		drain_pipeline();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		pressure_count = '0;
		temperature_count = '0;
		cal = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_uncalibrated();
		test_full_scale_coeffs();
		test_cold_thresholds();
		test_random_calibrations();
		test_output_backpressure();
		test_full_rate_stream();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/bptc_pkg.sv
rtl/core/bptc_regs.sv
rtl/core/baro_pressure_temp_compensation.sv
tb/sv/baro_pressure_temp_compensation_tb.sv
